### hdl/cau_pkg.sv
// Shared constants, codes and types of the complex arithmetic unit.
package cau_pkg;

   // Fixed-point format and field widths
   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int TOL_W      = 31;
   localparam int CMD_W      = 3;
   localparam int ST_W       = 2;
   localparam int REQ_DATA_W = 4 * DATA_W;
   localparam int RSP_DATA_W = ((2 * DATA_W + 1 + 7) / 8) * 8;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(16);

   // Divider: quotient bits resolved one per stage, plus entry and exit stages
   localparam int Q_BITS  = 33;
   localparam int DIV_LAT = Q_BITS + 2;

   // Queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int FIFO_CW    = 3;

   // Operation selector codes on the request side
   localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CMP = 3'd4;

   // Classified operation carried from front to back
   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_DIVZ = 3'd5,
      OP_CMP  = 3'd6
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK   = 2'd0,
      ST_DIVZ = 2'd1,
      ST_SAT  = 2'd2
   } status_type;

   typedef struct packed {
      op_type            op;
      logic [DATA_W-1:0] a_re;
      logic [DATA_W-1:0] a_im;
      logic [DATA_W-1:0] b_re;
      logic [DATA_W-1:0] b_im;
   } item_type;

   typedef struct packed {
      op_type            op;
      logic [DATA_W-1:0] res_re;
      logic [DATA_W-1:0] res_im;
      logic              is_equal;
      status_type        status;
   } tag_type;

endpackage

### hdl/cau_front.sv
// Front end: accepts request beats and classifies the operation.
module cau_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cau_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [cau_pkg::CMD_W-1:0]          req_tuser,
   output logic                               out_valid,
   output cau_pkg::item_type                  out_item,
   input  logic                               out_ready
);

   logic              valid_ff, valid_in;
   cau_pkg::item_type item_ff, item_in;
   logic              accept;
   logic              b_zero;

   assign req_tready = !valid_ff || out_ready;
   assign accept     = req_tvalid && req_tready;

   // Decode the selector; a divide by zero is flagged here
   always_comb begin
      item_in.a_re = req_tdata[cau_pkg::DATA_W-1:0];
      item_in.a_im = req_tdata[2*cau_pkg::DATA_W-1:cau_pkg::DATA_W];
      item_in.b_re = req_tdata[3*cau_pkg::DATA_W-1:2*cau_pkg::DATA_W];
      item_in.b_im = req_tdata[4*cau_pkg::DATA_W-1:3*cau_pkg::DATA_W];
      b_zero = (item_in.b_re == '0) && (item_in.b_im == '0);
      case (req_tuser)
         cau_pkg::CMD_ADD: item_in.op = cau_pkg::OP_ADD;
         cau_pkg::CMD_SUB: item_in.op = cau_pkg::OP_SUB;
         cau_pkg::CMD_MUL: item_in.op = cau_pkg::OP_MUL;
         cau_pkg::CMD_DIV: item_in.op = b_zero ? cau_pkg::OP_DIVZ : cau_pkg::OP_DIV;
         cau_pkg::CMD_CMP: item_in.op = cau_pkg::OP_CMP;
         default:          item_in.op = cau_pkg::OP_NONE;
      endcase
   end

   // Hold the beat until the queue takes it
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### hdl/cau_fifo.sv
// Short queue of classified items between front and back.
module cau_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cau_pkg::item_type push_item,
   output logic              ready,
   input  logic              pop,
   output cau_pkg::item_type pop_item,
   output logic              nonempty
);

   cau_pkg::item_type              slot_ff [cau_pkg::FIFO_DEPTH];
   logic [cau_pkg::FIFO_AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [cau_pkg::FIFO_CW-1:0]    count_ff, count_in;
   logic                           do_push, do_pop;

   assign ready    = (count_ff != cau_pkg::FIFO_CW'(cau_pkg::FIFO_DEPTH));
   assign nonempty = (count_ff != '0);
   assign do_push  = push && ready;
   assign do_pop   = pop && nonempty;
   assign pop_item = slot_ff[rd_ptr_ff];

   // Track fill level
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cau_pkg::FIFO_CW'(cau_pkg::FIFO_DEPTH))
      else $error("queue fill count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push && count_ff == cau_pkg::FIFO_CW'(1)) |=> !nonempty)
      else $error("queue not empty after last entry left");

endmodule

### hdl/cau_div.sv
// Pipelined restoring divider: scaled magnitude over divisor, one quotient bit per stage.
module cau_div (
   input  logic                           clock,
   input  logic                           adv,
   input  logic                           neg,
   input  logic [cau_pkg::PROD_W-1:0]     mag,
   input  logic [cau_pkg::PROD_W-1:0]     den,
   output logic [cau_pkg::DATA_W-1:0]     quo,
   output logic                           sat
);

   localparam int NW = cau_pkg::PROD_W + cau_pkg::FRAC_BITS;
   localparam int QB = cau_pkg::Q_BITS;
   localparam logic [QB-1:0] POS_LIM = QB'(64'h7FFF_FFFF);
   localparam logic [QB-1:0] NEG_LIM = QB'(64'h8000_0000);
   localparam logic [cau_pkg::DATA_W-1:0] MAX_V = 32'h7FFF_FFFF;
   localparam logic [cau_pkg::DATA_W-1:0] MIN_V = 32'h8000_0000;

   logic [cau_pkg::PROD_W-1:0] rem_ff [QB+1];
   logic [cau_pkg::PROD_W-1:0] den_ff [QB+1];
   logic [QB-1:0]              low_ff [QB+1];
   logic [QB-1:0]              q_ff   [QB+1];
   logic                       neg_ff [QB+1];
   logic                       ovf_ff [QB+1];

   logic [NW-1:0]              num;
   logic [NW-QB-1:0]           hi;
   logic                       ovf;
   logic [cau_pkg::PROD_W-1:0] shifted [QB+1];
   logic [cau_pkg::PROD_W:0]   diff    [QB+1];

   logic [cau_pkg::DATA_W-1:0] quo_ff, quo_in;
   logic                       sat_ff, sat_in;

   // Entry: a quotient of 2^Q_BITS or more is caught up front
   always_comb begin
      num = NW'(mag) << cau_pkg::FRAC_BITS;
      hi  = num[NW-1:QB];
      ovf = cau_pkg::PROD_W'(hi) >= den;
   end

   // Trial subtract for each stage
   always_comb begin
      shifted[0] = '0;
      diff[0]    = '0;
      for (int k = 1; k <= QB; k++) begin
         shifted[k] = {rem_ff[k-1][cau_pkg::PROD_W-2:0], low_ff[k-1][QB-1]};
         diff[k]    = {1'b0, shifted[k]} - {1'b0, den_ff[k-1]};
      end
   end

   // Advance the stages
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= ovf ? '0 : cau_pkg::PROD_W'(hi);
         den_ff[0] <= den;
         low_ff[0] <= num[QB-1:0];
         q_ff[0]   <= '0;
         neg_ff[0] <= neg;
         ovf_ff[0] <= ovf;
         for (int k = 1; k <= QB; k++) begin
            rem_ff[k] <= diff[k][cau_pkg::PROD_W] ? shifted[k]
                                                  : diff[k][cau_pkg::PROD_W-1:0];
            den_ff[k] <= den_ff[k-1];
            low_ff[k] <= {low_ff[k-1][QB-2:0], 1'b0};
            q_ff[k]   <= {q_ff[k-1][QB-2:0], !diff[k][cau_pkg::PROD_W]};
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
         quo_ff <= quo_in;
         sat_ff <= sat_in;
      end
   end

   // Apply sign and saturate
   always_comb begin
      sat_in = 1'b0;
      if (neg_ff[QB]) begin
         quo_in = ~q_ff[QB][cau_pkg::DATA_W-1:0] + 1'b1;
         if (ovf_ff[QB] || q_ff[QB] > NEG_LIM) begin
            sat_in = 1'b1;
            quo_in = MIN_V;
         end
      end else begin
         quo_in = q_ff[QB][cau_pkg::DATA_W-1:0];
         if (ovf_ff[QB] || q_ff[QB] > POS_LIM) begin
            sat_in = 1'b1;
            quo_in = MAX_V;
         end
      end
   end

   assign quo = quo_ff;
   assign sat = sat_ff;

endmodule

### hdl/cau_back.sv
// Back end: products, sums, comparison, division and saturation, with the result register.
module cau_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cau_pkg::TOL_W-1:0]         tol,
   input  logic                              in_valid,
   input  cau_pkg::item_type                 in_item,
   output logic                              in_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cau_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [cau_pkg::ST_W-1:0]          rsp_tuser
);

   localparam int DW = cau_pkg::DATA_W;
   localparam int PW = cau_pkg::PROD_W;
   localparam int SW = cau_pkg::SUM_W;
   localparam int FB = cau_pkg::FRAC_BITS;
   localparam int LAT = cau_pkg::DIV_LAT;
   localparam logic [DW-1:0] MAX_V = 32'h7FFF_FFFF;
   localparam logic [DW-1:0] MIN_V = 32'h8000_0000;

   logic adv;

   // Stage 1: products and the operations that finish here (add, subtract, compare, divide by zero)
   logic                    v1_ff;
   cau_pkg::tag_type        t1_ff, t1_in;
   logic signed [PW-1:0]    p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_dr_ff, p_di_ff;
   logic signed [PW-1:0]    p_rr_in, p_ii_in, p_ri_in, p_ir_in, p_dr_in, p_di_in;
   logic [DW:0]             s_re, s_im, d_re, d_im, m_re, m_im;
   logic                    sat_re, sat_im;
   logic [DW-1:0]           o_re, o_im;

   // Stage 2: sums of products
   logic                    v2_ff;
   cau_pkg::tag_type        t2_ff;
   logic [SW-1:0]           mre_ff, mim_ff, nre_ff, nim_ff;
   logic [PW-1:0]           den2_ff;

   // Stage 3: multiply result, divider operands
   logic                    v3_ff;
   cau_pkg::tag_type        t3_ff, t3_in;
   logic                    dneg_re_ff, dneg_im_ff;
   logic [PW-1:0]           dmag_re_ff, dmag_im_ff, den3_ff;
   logic [SW-1:0]           neg_nre, neg_nim;
   logic [DW:0]             x_re, x_im;

   // Delay line alongside the divider
   logic                    vl_ff [LAT];
   cau_pkg::tag_type        tl_ff [LAT];
   logic [DW-1:0]           q_re, q_im;
   logic                    q_re_sat, q_im_sat;

   // Result register
   logic                    rv_ff;
   cau_pkg::tag_type        r_ff, r_in;

   function automatic logic [DW:0] sat33(input logic [DW:0] s);
      logic [DW:0] res;
      res = {1'b0, s[DW-1:0]};
      if (s[DW] != s[DW-1]) begin
         res = {1'b1, s[DW] ? MIN_V : MAX_V};
      end
      return res;
   endfunction

   function automatic logic [DW:0] sat_mul(input logic [SW-1:0] m);
      logic [SW-DW-FB:0] top;
      logic [DW:0]       res;
      top = m[SW-1:DW+FB-1];
      res = {1'b0, m[DW+FB-1:FB]};
      if (!((&top) || !(|top))) begin
         res = {1'b1, m[SW-1] ? MIN_V : MAX_V};
      end
      return res;
   endfunction

   function automatic logic [DW:0] abs33(input logic [DW:0] d);
      return d[DW] ? (~d + 1'b1) : d;
   endfunction

   assign adv    = !rv_ff || rsp_tready;
   assign in_pop = adv && in_valid;

   // Stage 1 logic
   always_comb begin
      p_rr_in = $signed(in_item.a_re) * $signed(in_item.b_re);
      p_ii_in = $signed(in_item.a_im) * $signed(in_item.b_im);
      p_ri_in = $signed(in_item.a_re) * $signed(in_item.b_im);
      p_ir_in = $signed(in_item.a_im) * $signed(in_item.b_re);
      p_dr_in = $signed(in_item.b_re) * $signed(in_item.b_re);
      p_di_in = $signed(in_item.b_im) * $signed(in_item.b_im);
      s_re = {in_item.a_re[DW-1], in_item.a_re} + {in_item.b_re[DW-1], in_item.b_re};
      s_im = {in_item.a_im[DW-1], in_item.a_im} + {in_item.b_im[DW-1], in_item.b_im};
      d_re = {in_item.a_re[DW-1], in_item.a_re} - {in_item.b_re[DW-1], in_item.b_re};
      d_im = {in_item.a_im[DW-1], in_item.a_im} - {in_item.b_im[DW-1], in_item.b_im};
      m_re = '0;
      m_im = '0;
      t1_in.op       = in_item.op;
      t1_in.res_re   = '0;
      t1_in.res_im   = '0;
      t1_in.is_equal = 1'b0;
      t1_in.status   = cau_pkg::ST_OK;
      case (in_item.op)
         cau_pkg::OP_ADD: begin
            m_re = sat33(s_re);
            m_im = sat33(s_im);
         end
         cau_pkg::OP_SUB: begin
            m_re = sat33(d_re);
            m_im = sat33(d_im);
         end
         cau_pkg::OP_CMP: begin
            t1_in.is_equal = (abs33(d_re) < (DW+1)'(tol)) && (abs33(d_im) < (DW+1)'(tol));
         end
         cau_pkg::OP_DIVZ: begin
            t1_in.status = cau_pkg::ST_DIVZ;
         end
         default: begin
            m_re = '0;
         end
      endcase
      {sat_re, o_re} = m_re;
      {sat_im, o_im} = m_im;
      t1_in.res_re = o_re;
      t1_in.res_im = o_im;
      if (sat_re || sat_im) begin
         t1_in.status = cau_pkg::ST_SAT;
      end
   end

   // Stage 3 logic
   always_comb begin
      t3_in   = t2_ff;
      neg_nre = ~nre_ff + 1'b1;
      neg_nim = ~nim_ff + 1'b1;
      x_re    = sat_mul(mre_ff);
      x_im    = sat_mul(mim_ff);
      if (t2_ff.op == cau_pkg::OP_MUL) begin
         t3_in.res_re = x_re[DW-1:0];
         t3_in.res_im = x_im[DW-1:0];
         t3_in.status = (x_re[DW] || x_im[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
   end

   // Pick the divider result for divides
   always_comb begin
      r_in = tl_ff[LAT-1];
      if (tl_ff[LAT-1].op == cau_pkg::OP_DIV) begin
         r_in.res_re = q_re;
         r_in.res_im = q_im;
         r_in.status = (q_re_sat || q_im_sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
   end

   // Valid bits of every stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         rv_ff <= 1'b0;
         for (int k = 0; k < LAT; k++) begin
            vl_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff    <= in_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         vl_ff[0] <= v3_ff;
         for (int k = 1; k < LAT; k++) begin
            vl_ff[k] <= vl_ff[k-1];
         end
         rv_ff <= vl_ff[LAT-1];
      end
   end

   // Advance payload; the whole pipeline holds while the result waits
   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff   <= t1_in;
         p_rr_ff <= p_rr_in;
         p_ii_ff <= p_ii_in;
         p_ri_ff <= p_ri_in;
         p_ir_ff <= p_ir_in;
         p_dr_ff <= p_dr_in;
         p_di_ff <= p_di_in;

         t2_ff   <= t1_ff;
         mre_ff  <= {p_rr_ff[PW-1], p_rr_ff} - {p_ii_ff[PW-1], p_ii_ff};
         mim_ff  <= {p_ri_ff[PW-1], p_ri_ff} + {p_ir_ff[PW-1], p_ir_ff};
         nre_ff  <= {p_rr_ff[PW-1], p_rr_ff} + {p_ii_ff[PW-1], p_ii_ff};
         nim_ff  <= {p_ir_ff[PW-1], p_ir_ff} - {p_ri_ff[PW-1], p_ri_ff};
         den2_ff <= p_dr_ff + p_di_ff;

         t3_ff      <= t3_in;
         dneg_re_ff <= nre_ff[SW-1];
         dneg_im_ff <= nim_ff[SW-1];
         dmag_re_ff <= nre_ff[SW-1] ? neg_nre[PW-1:0] : nre_ff[PW-1:0];
         dmag_im_ff <= nim_ff[SW-1] ? neg_nim[PW-1:0] : nim_ff[PW-1:0];
         den3_ff    <= den2_ff;

         tl_ff[0] <= t3_ff;
         for (int k = 1; k < LAT; k++) begin
            tl_ff[k] <= tl_ff[k-1];
         end
         r_ff <= r_in;
      end
   end

   cau_div u_div_re (
      .clock (clock),
      .adv   (adv),
      .neg   (dneg_re_ff),
      .mag   (dmag_re_ff),
      .den   (den3_ff),
      .quo   (q_re),
      .sat   (q_re_sat)
   );

   cau_div u_div_im (
      .clock (clock),
      .adv   (adv),
      .neg   (dneg_im_ff),
      .mag   (dmag_im_ff),
      .den   (den3_ff),
      .quo   (q_im),
      .sat   (q_im_sat)
   );

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {{(cau_pkg::RSP_DATA_W - 2*DW - 1){1'b0}},
                        r_ff.is_equal, r_ff.res_im, r_ff.res_re};
   assign rsp_tuser  = r_ff.status;

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && r_ff.status == cau_pkg::ST_DIVZ) |->
         (r_ff.res_re == '0 && r_ff.res_im == '0 && !r_ff.is_equal))
      else $error("divide by zero result not cleared");

   a_equal_ok: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && r_ff.is_equal) |-> (r_ff.status == cau_pkg::ST_OK))
      else $error("equal flag with non-ok status");

   a_divz_flow: assert property (@(posedge clock) disable iff (reset)
      (adv && vl_ff[LAT-1] && tl_ff[LAT-1].op == cau_pkg::OP_DIVZ) |=>
         (rv_ff && r_ff.status == cau_pkg::ST_DIVZ))
      else $error("divide by zero status lost on the way out");

endmodule

### hdl/complex_arith_unit.sv
// Top level of the complex arithmetic unit: front, queue, back and tolerance register.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata a_re,a_im,b_re,b_im; tuser cmd
//   rsp      out  rsp_tvalid/rsp_tready  tdata res_re,res_im,is_equal; tuser status
//   csr      in   csr_wen                csr_wdata eq_tolerance
//
// One beat per cycle sustained in both directions while rsp_tready stays high. A beat
// passes through the front register and the queue, then three arithmetic stages,
// the 35-stage pipelined divider path and the result register.
// A stalled result holds the whole back pipeline; the queue lets the front keep accepting until it is full.
// Synchronous reset empties the pipeline and sets the tolerance to 16.
module complex_arith_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wen,
   input  logic [cau_pkg::TOL_W-1:0]          csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cau_pkg::REQ_DATA_W-1:0]     req_tdata,   // a_re, a_im, b_re, b_im
   input  logic [cau_pkg::CMD_W-1:0]          req_tuser,   // cmd
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cau_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // res_re, res_im, is_equal, zeros
   output logic [cau_pkg::ST_W-1:0]           rsp_tuser    // status
);

   logic [cau_pkg::TOL_W-1:0] tol_ff;
   logic                      f_valid, f_ready;
   cau_pkg::item_type         f_item;
   logic                      q_nonempty, q_pop;
   cau_pkg::item_type         q_item;

   // Hold the compare tolerance
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= cau_pkg::TOL_RESET;
      end else if (csr_wen) begin
         tol_ff <= csr_wdata;
      end
   end

   cau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .out_valid  (f_valid),
      .out_item   (f_item),
      .out_ready  (f_ready)
   );

   cau_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_item (f_item),
      .ready     (f_ready),
      .pop       (q_pop),
      .pop_item  (q_item),
      .nonempty  (q_nonempty)
   );

   cau_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tol        (tol_ff),
      .in_valid   (q_nonempty),
      .in_item    (q_item),
      .in_pop     (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
